@@ src/fls_pkg.sv @@
// Shared constants, types and helpers for the flash log page scanner.
package fls_pkg;

  localparam int PAGE_WORDS   = 1024;
  localparam int HEADER_WORDS = 6;
  localparam int TAG_WORDS    = 2;

  localparam int OFF_W     = $clog2(PAGE_WORDS + 1);
  localparam int OUT_OFF_W = 11;
  localparam int LEN_W     = 16;
  localparam int ID_W      = 32;
  localparam int KEY_W     = 16;
  localparam int CNT_W     = 16;
  localparam int FREE_W    = 24;
  localparam int VERD_W    = 3;
  localparam int JUMP_W    = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef logic [OFF_W-1:0] off_t;

  localparam off_t TAG_OFF    = OFF_W'(TAG_WORDS);
  localparam off_t PAGE_OFF   = OFF_W'(PAGE_WORDS);
  localparam bit   START_DONE = (TAG_WORDS >= PAGE_WORDS);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_START  = 2'd1,
    CMD_HEADER = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [VERD_W-1:0] {
    V_VALID   = 3'd0,
    V_DIRTY   = 3'd1,
    V_CORRUPT = 3'd2,
    V_END     = 3'd3,
    V_INFO    = 3'd4
  } verdict_t;

  typedef enum logic {
    REG_INVALID_FILE_ID = 1'b0,
    REG_DIRTY_KEY       = 1'b1
  } reg_idx_t;

  // Classified header as it waits between front and back.
  typedef struct packed {
    cmd_t             cmd;
    logic             lead_erased;
    logic             dirty;
    logic [LEN_W-1:0] data_len;
    logic [ID_W-1:0]  record_id;
  } hdr_word_t;

  function automatic logic [OUT_OFF_W-1:0] to_out_off(input off_t x);
    logic [OFF_W+OUT_OFF_W-1:0] ext;
    ext = {{OUT_OFF_W{1'b0}}, x};
    return ext[OUT_OFF_W-1:0];
  endfunction

endpackage

@@ src/fls_if.sv @@
// Word channel interfaces: header words in, scan results out.
interface fls_hdr_if
  import fls_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic             lead_word_erased;
  logic [15:0]      file_id;
  logic [15:0]      record_key;
  logic [LEN_W-1:0] data_len;
  logic [ID_W-1:0]  record_id;
  logic             gc_tag_erased;

  modport source (output valid, cmd, lead_word_erased, file_id, record_key, data_len,
                  record_id, gc_tag_erased, input ready);
  modport sink (input valid, cmd, lead_word_erased, file_id, record_key, data_len,
                record_id, gc_tag_erased, output ready);
endinterface

interface fls_res_if
  import fls_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [VERD_W-1:0]    verdict;
  logic [OUT_OFF_W-1:0] next_offset;
  logic                 scan_done;
  logic [OUT_OFF_W-1:0] write_offset;
  logic [ID_W-1:0]      largest_id;
  logic [CNT_W-1:0]     valid_count;
  logic [CNT_W-1:0]     dirty_count;
  logic [FREE_W-1:0]    freeable_words;
  logic                 corruption;

  modport source (output valid, verdict, next_offset, scan_done, write_offset, largest_id,
                  valid_count, dirty_count, freeable_words, corruption, input ready);
  modport sink (input valid, verdict, next_offset, scan_done, write_offset, largest_id,
                valid_count, dirty_count, freeable_words, corruption, output ready);
endinterface

@@ src/fls_front.sv @@
// Front end: config registers, header intake and dirty classification.
module fls_front
  import fls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  fls_hdr_if.sink           hdr,
  input  logic              q_full,
  output logic              push,
  output hdr_word_t         push_word
);

  logic [15:0] invalid_file_id;
  logic [15:0] dirty_key_value;
  reg_idx_t    reg_sel;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_file_id <= 16'hFFFF;
      dirty_key_value <= 16'h0000;
    end else if (wr_en) begin
      case (reg_sel)
        REG_INVALID_FILE_ID: invalid_file_id <= pwdata[15:0];
        REG_DIRTY_KEY:       dirty_key_value <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INVALID_FILE_ID: prdata = {16'h0000, invalid_file_id};
      REG_DIRTY_KEY:       prdata = {16'h0000, dirty_key_value};
      default:             prdata = '0;
    endcase
  end

  assign hdr.ready = !q_full;
  assign push      = hdr.valid && !q_full;

  // Dirty test needs only the header and config, so it is done before queuing.
  always_comb begin
    push_word.cmd         = cmd_t'(hdr.cmd);
    push_word.lead_erased = hdr.lead_word_erased;
    push_word.dirty       = (hdr.file_id == invalid_file_id)
                         || (hdr.record_key == dirty_key_value)
                         || (hdr.record_id == {ID_W{1'b1}})
                         || !hdr.gc_tag_erased;
    push_word.data_len    = hdr.data_len;
    push_word.record_id   = hdr.record_id;
  end

endmodule

@@ src/fls_queue.sv @@
// Short word queue between the classifier and the scan engine.
module fls_queue
  import fls_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hdr_word_t push_word,
  output logic      full,
  input  logic      pop,
  output hdr_word_t pop_word,
  output logic      empty
);

  hdr_word_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_pop   = pop && !empty;
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/fls_back.sv @@
// Scan engine: page walk state, statistics and the result register.
module fls_back
  import fls_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  hdr_word_t q_word,
  output logic      pop,
  fls_res_if.source res
);

  off_t              offset, offset_next;
  logic              finished, finished_next;
  logic [ID_W-1:0]   max_id, max_id_next;
  logic [CNT_W-1:0]  valid_total, valid_total_next;
  logic [CNT_W-1:0]  dirty_total, dirty_total_next;
  logic [FREE_W-1:0] free_total, free_total_next;
  logic              corrupt_seen, corrupt_seen_next;
  verdict_t          verdict, verdict_next;
  logic [JUMP_W-1:0] jump;
  logic [JUMP_W-1:0] hdr_len;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    return (a == {CNT_W{1'b1}}) ? a : a + 1'b1;
  endfunction

  function automatic logic [FREE_W-1:0] sat_add(input logic [FREE_W-1:0] a,
                                                input logic [JUMP_W-1:0] b);
    logic [FREE_W:0] s;
    s = (FREE_W+1)'(a) + (FREE_W+1)'(b);
    return s[FREE_W] ? {FREE_W{1'b1}} : s[FREE_W-1:0];
  endfunction

  // Results only change on a take, so a stalled result holds by itself.
  assign pop = !q_empty && (!res.valid || res.ready);

  assign hdr_len = JUMP_W'(HEADER_WORDS) + JUMP_W'(q_word.data_len);
  assign jump    = JUMP_W'(offset) + hdr_len;

  always_comb begin
    offset_next       = offset;
    finished_next     = finished;
    max_id_next       = max_id;
    valid_total_next  = valid_total;
    dirty_total_next  = dirty_total;
    free_total_next   = free_total;
    corrupt_seen_next = corrupt_seen;
    verdict_next      = V_INFO;
    case (q_word.cmd)
      CMD_CLEAR: begin
        valid_total_next  = '0;
        dirty_total_next  = '0;
        free_total_next   = '0;
        corrupt_seen_next = 1'b0;
      end
      CMD_START: begin
        offset_next   = TAG_OFF;
        finished_next = START_DONE;
      end
      CMD_HEADER: begin
        if (finished || offset >= PAGE_OFF || q_word.lead_erased) begin
          finished_next = 1'b1;
          verdict_next  = V_END;
        end else if (jump > JUMP_W'(PAGE_WORDS)) begin
          // length overruns the page: rest of page is lost
          verdict_next      = V_CORRUPT;
          dirty_total_next  = sat_inc(dirty_total);
          free_total_next   = sat_add(free_total, JUMP_W'(PAGE_OFF - offset));
          corrupt_seen_next = 1'b1;
          offset_next       = PAGE_OFF;
          finished_next     = 1'b1;
        end else begin
          if (q_word.dirty) begin
            verdict_next     = V_DIRTY;
            dirty_total_next = sat_inc(dirty_total);
            free_total_next  = sat_add(free_total, hdr_len);
          end else begin
            verdict_next     = V_VALID;
            valid_total_next = sat_inc(valid_total);
            if (q_word.record_id > max_id) begin
              max_id_next = q_word.record_id;
            end
          end
          offset_next = jump[OFF_W-1:0];
          if (jump >= JUMP_W'(PAGE_WORDS)) begin
            finished_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset       <= TAG_OFF;
      finished     <= 1'b1;
      max_id       <= '0;
      valid_total  <= '0;
      dirty_total  <= '0;
      free_total   <= '0;
      corrupt_seen <= 1'b0;
      verdict      <= V_INFO;
      res.valid    <= 1'b0;
    end else if (pop) begin
      offset       <= offset_next;
      finished     <= finished_next;
      max_id       <= max_id_next;
      valid_total  <= valid_total_next;
      dirty_total  <= dirty_total_next;
      free_total   <= free_total_next;
      corrupt_seen <= corrupt_seen_next;
      verdict      <= verdict_next;
      res.valid    <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  assign res.verdict        = verdict;
  assign res.next_offset    = to_out_off(offset);
  assign res.scan_done      = finished;
  assign res.write_offset   = to_out_off(offset);
  assign res.largest_id     = max_id;
  assign res.valid_count    = valid_total;
  assign res.dirty_count    = dirty_total;
  assign res.freeable_words = free_total;
  assign res.corruption     = corrupt_seen;

endmodule

@@ src/flash_log_page_scanner.sv @@
// Top level of the flash log page scanner.
//
// hdr carries one word per decoded record header (or a clear / start
// command); res returns exactly one result word per accepted word, in order.
// The APB port holds invalid_file_id (0x0) and dirty_key_value (0x4); write
// them only while the scanner is idle. pready is tied high.
//
// A word accepted on hdr is written into the queue, popped by the scan
// engine and registered into the result. Throughput is one word per cycle
// while res takes its results.
//
// Reset (rst, synchronous): offset goes to the tag size, the page counts as
// finished (send a start word first), all statistics and largest_id clear,
// config registers return to 0xFFFF and 0x0000, the queue empties.
// When res stalls, the result holds and the four-entry queue fills; hdr
// deasserts ready once the queue is full.
module flash_log_page_scanner
  import fls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  fls_hdr_if.sink           hdr,
  fls_res_if.source         res
);

  logic      push;
  hdr_word_t push_word;
  logic      q_full;
  logic      q_empty;
  logic      pop;
  hdr_word_t q_word;

  fls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .hdr       (hdr),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  fls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .pop_word  (q_word),
    .empty     (q_empty)
  );

  fls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_word  (q_word),
    .pop     (pop),
    .res     (res)
  );

endmodule

@@ src/fls_checker.sv @@
// Port-level assertions for the flash log page scanner, bound to the top.
module fls_checker
  import fls_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 pready,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [VERD_W-1:0]    verdict,
  input logic [OUT_OFF_W-1:0] next_offset,
  input logic [OUT_OFF_W-1:0] write_offset,
  input logic                 scan_done,
  input logic                 corruption,
  input logic [CNT_W-1:0]     valid_count,
  input logic [CNT_W-1:0]     dirty_count
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(verdict) && $stable(next_offset))
    else $error("result changed while stalled");

  a_corrupt_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid && verdict == V_CORRUPT |-> scan_done && corruption && dirty_count != '0)
    else $error("corrupt verdict without done, flag or dirty count");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && verdict == V_VALID |-> valid_count != '0)
    else $error("valid verdict with zero valid count");

  a_offsets_agree: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> next_offset == write_offset)
    else $error("next and write offset differ");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && verdict == V_END |-> scan_done && pready)
    else $error("end of records without scan done");

endmodule

bind flash_log_page_scanner fls_checker u_fls_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .verdict      (res.verdict),
  .next_offset  (res.next_offset),
  .write_offset (res.write_offset),
  .scan_done    (res.scan_done),
  .corruption   (res.corruption),
  .valid_count  (res.valid_count),
  .dirty_count  (res.dirty_count)
);
